// ===== design/rsm_pkg.sv =====
`default_nettype none
package rsm_pkg;

  localparam int unsigned OUT_COUNT_W = 7;

  typedef struct packed {
    logic ins;
    logic shift;
  } rsm_ctl_t;

endpackage
`default_nettype wire

// ===== design/rsm_cell.sv =====
`default_nettype none
module rsm_cell
  import rsm_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire rsm_ctl_t                      ctl,
  input  wire logic                          valid,
  input  wire logic signed [VALUE_WIDTH-1:0] sample,
  input  wire logic                          left_keep,
  input  wire logic signed [VALUE_WIDTH-1:0] left_val,
  input  wire logic signed [VALUE_WIDTH-1:0] right_val,
  output logic                               keep,
  output logic signed [VALUE_WIDTH-1:0]      val
);

  logic signed [VALUE_WIDTH-1:0] val_r;
  logic signed [VALUE_WIDTH-1:0] val_nxt;

  // a valid entry not above the new sample stays in place
  assign keep = valid && (val_r <= sample);
  assign val  = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins) begin
      if (keep) begin
        val_nxt = val_r;
      end else if (left_keep) begin
        val_nxt = sample;
      end else begin
        val_nxt = left_val;
      end
    end else if (ctl.shift) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

// ===== design/running_set_median_unit.sv =====
`default_nettype none
// A value-only transaction is inserted, or dropped when full; busy stays low.
// A closing transaction with n > 0 kept values raises busy: the cell chain shifts
// one entry a cycle toward cell 0 until the middle pair is read, then out_valid rises.
// An empty set skips the shift and raises out_valid from ST_MEAN.
// Throughput: one value per cycle while the set fills; busy during readout.
// Reset: synchronous, active low; clears count, overflow flag and control.
// The receiver cannot stall: out_valid is a one-cycle strobe.
module running_set_median_unit
  import rsm_pkg::*;
#(
  parameter int unsigned MAX_COUNT   = 64,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [VALUE_WIDTH-1:0] in_sample,
  input  wire logic                          in_has_sample,
  input  wire logic                          in_closes_set,
  output logic                               out_valid,
  output logic signed [VALUE_WIDTH-1:0]      out_median,
  output logic [OUT_COUNT_W-1:0]             out_set_count,
  output logic                               out_overflowed
);

  localparam int unsigned CNT_W = $clog2(MAX_COUNT + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_MEAN
  } state_t;

  state_t                        state_r;
  logic [CNT_W-1:0]              count_r;
  logic [CNT_W-1:0]              step_r;
  logic                          drop_r;
  logic signed [VALUE_WIDTH-1:0] lo_val_r;
  logic signed [VALUE_WIDTH-1:0] hi_val_r;
  logic                          out_valid_r;
  logic signed [VALUE_WIDTH-1:0] out_median_r;
  logic [OUT_COUNT_W-1:0]        out_count_r;
  logic                          out_ovf_r;

  logic                          accept;
  logic                          full;
  rsm_ctl_t                      ctl;
  logic [CNT_W-1:0]              count_ins;
  logic [CNT_W-1:0]              lo_idx;
  logic [CNT_W-1:0]              hi_idx;
  logic signed [VALUE_WIDTH:0]   pair_sum;
  logic signed [VALUE_WIDTH:0]   mean_full;

  logic                          keep_w [MAX_COUNT];
  logic signed [VALUE_WIDTH-1:0] val_w  [MAX_COUNT];

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign full      = (count_r == CNT_W'(MAX_COUNT));
  assign ctl.ins   = accept && in_has_sample && !full;
  assign ctl.shift = (state_r == ST_DRAIN);
  assign count_ins = count_r + CNT_W'(ctl.ins);
  assign lo_idx    = (count_r - CNT_W'(1)) >> 1;
  assign hi_idx    = count_r >> 1;

  // mean of the middle pair, exact half away from zero
  assign pair_sum  = {lo_val_r[VALUE_WIDTH-1], lo_val_r}
                   + {hi_val_r[VALUE_WIDTH-1], hi_val_r};
  assign mean_full = pair_sum[VALUE_WIDTH] ? (pair_sum >>> 1)
                                           : ((pair_sum + (VALUE_WIDTH+1)'(1)) >>> 1);

  for (genvar i = 0; i < MAX_COUNT; i++) begin : g_cell
    logic                          left_keep;
    logic signed [VALUE_WIDTH-1:0] left_val;
    logic signed [VALUE_WIDTH-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_keep = 1'b1;
      assign left_val  = in_sample;
    end else begin : g_mid
      assign left_keep = keep_w[i-1];
      assign left_val  = val_w[i-1];
    end

    if (i == MAX_COUNT - 1) begin : g_last
      assign right_val = val_w[i];
    end else begin : g_inner
      assign right_val = val_w[i+1];
    end

    rsm_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .valid     (CNT_W'(i) < count_r),
      .sample    (in_sample),
      .left_keep (left_keep),
      .left_val  (left_val),
      .right_val (right_val),
      .keep      (keep_w[i]),
      .val       (val_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            count_r <= count_ins;
            if (in_has_sample && full) begin
              drop_r <= 1'b1;
            end
            if (in_closes_set) begin
              step_r <= '0;
              if (count_ins == '0) begin
                lo_val_r <= '0;
                hi_val_r <= '0;
                state_r  <= ST_MEAN;
              end else begin
                state_r <= ST_DRAIN;
              end
            end
          end
        end
        ST_DRAIN: begin
          // cell 0 holds the entry of rank step_r
          if (step_r == lo_idx) begin
            lo_val_r <= val_w[0];
          end
          if (step_r == hi_idx) begin
            hi_val_r <= val_w[0];
            state_r  <= ST_MEAN;
          end
          step_r <= step_r + CNT_W'(1);
        end
        ST_MEAN: begin
          out_valid_r  <= 1'b1;
          out_median_r <= mean_full[VALUE_WIDTH-1:0];
          out_count_r  <= OUT_COUNT_W'(count_r);
          out_ovf_r    <= drop_r;
          count_r      <= '0;
          drop_r       <= 1'b0;
          state_r      <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_median     = out_median_r;
  assign out_set_count  = out_count_r;
  assign out_overflowed = out_ovf_r;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
  import rsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH   = 64;
  localparam int unsigned VW      = 16;
  localparam int unsigned DRAIN   = DEPTH / 2 + 8;
  localparam int unsigned LIMIT   = 400000;
  localparam int unsigned PER_PHASE = 233;

  typedef struct {
    logic signed [VW-1:0] sample;
    logic                 has;
    logic                 closes;
  } set_item_t;

  typedef struct {
    logic signed [VW-1:0]    median;
    logic [OUT_COUNT_W-1:0]  count;
    logic                    ovf;
  } median_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic signed [VW-1:0] in_sample = '0;
  logic in_has_sample = 1'b0;
  logic in_closes_set = 1'b0;
  logic busy;
  logic out_valid;
  logic signed [VW-1:0] out_median;
  logic [OUT_COUNT_W-1:0] out_set_count;
  logic out_overflowed;

  set_item_t   pending_items[$];
  median_res_t expected_medians[$];
  int          kept_vals[$];
  logic        kept_dropped = 1'b0;
  int          errors = 0;
  int          cycle_cnt = 0;
  int          idle_pct = 0;
  bit          taken = 1'b0;
  bit          have_cur = 1'b0;
  set_item_t   cur_item;

  running_set_median_unit #(.MAX_COUNT(DEPTH), .VALUE_WIDTH(VW)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sample(in_sample), .in_has_sample(in_has_sample), .in_closes_set(in_closes_set),
    .out_valid(out_valid), .out_median(out_median), .out_set_count(out_set_count),
    .out_overflowed(out_overflowed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report(input string msg);
    $display("mismatch @%0d: %s", cycle_cnt, msg);
    errors++;
  endtask

  function automatic logic signed [VW-1:0] kept_median();
    int n;
    int s;
    n = kept_vals.size();
    if (n == 0) return '0;
    if (n % 2 == 1) return VW'(kept_vals[(n - 1) / 2]);
    s = kept_vals[n / 2 - 1] + kept_vals[n / 2];
    if (s >= 0) return VW'((s + 1) / 2);
    return VW'(-((-s + 1) / 2));
  endfunction

  task automatic apply_transaction(input logic signed [VW-1:0] v, input logic has,
                                   input logic closes);
    int pos;
    median_res_t r;
    if (has) begin
      if (kept_vals.size() >= DEPTH) begin
        kept_dropped = 1'b1;
      end else begin
        pos = 0;
        while (pos < kept_vals.size() && kept_vals[pos] <= int'(v)) pos++;
        kept_vals.insert(pos, int'(v));
      end
    end
    if (closes) begin
      r.median = kept_median();
      r.count  = OUT_COUNT_W'(kept_vals.size());
      r.ovf    = kept_dropped;
      expected_medians = {expected_medians, r};
      kept_vals.delete();
      kept_dropped = 1'b0;
    end
  endtask

  // monitor: check results, then track accepted transactions
  always @(posedge clk) begin
    median_res_t e;
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      if (rst_n && out_valid) begin
        if (expected_medians.size() == 0) begin
          report($sformatf("unexpected result median=%0d count=%0d",
                           out_median, out_set_count));
        end else begin
          e = expected_medians.pop_front();
          if (out_median !== e.median)
            report($sformatf("median got %0d exp %0d", out_median, e.median));
          if (out_set_count !== e.count)
            report($sformatf("set_count got %0d exp %0d", out_set_count, e.count));
          if (out_overflowed !== e.ovf)
            report($sformatf("overflowed got %0b exp %0b", out_overflowed, e.ovf));
        end
      end
      taken = rst_n && start && !busy;
      if (taken) apply_transaction(in_sample, in_has_sample, in_closes_set);
    end
  end

  // driver
  always @(negedge clk) begin
    if (taken) have_cur = 1'b0;
    if (!have_cur && pending_items.size() > 0) begin
      cur_item = pending_items.pop_front();
      have_cur = 1'b1;
    end
    if (rst_n && have_cur && $urandom_range(99) >= idle_pct) begin
      start         <= 1'b1;
      in_sample     <= cur_item.sample;
      in_has_sample <= cur_item.has;
      in_closes_set <= cur_item.closes;
    end else begin
      start         <= 1'b0;
      in_sample     <= VW'($urandom);
      in_has_sample <= 1'($urandom_range(1));
      in_closes_set <= 1'($urandom_range(1));
    end
  end

  function automatic void push_item(input int v, input bit has, input bit closes);
    set_item_t it;
    it.sample = v[VW-1:0];
    it.has    = has;
    it.closes = closes;
    pending_items = {pending_items, it};
  endfunction

  // returns number of transactions queued (idle filler items not counted)
  function automatic int push_set(input int n, input bit narrow);
    bit close_with_sample;
    int cnt;
    int v;
    cnt = 0;
    close_with_sample = (n > 0) && $urandom_range(1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) push_item($urandom, 1'b0, 1'b0);
      v = narrow ? $urandom_range(8) - 4 : $urandom;
      push_item(v, 1'b1, close_with_sample && (i == n - 1));
      cnt++;
    end
    if (!close_with_sample) begin
      push_item($urandom, 1'b0, 1'b1);
      cnt++;
    end
    return cnt;
  endfunction

  task automatic wait_sent();
    while (pending_items.size() > 0 || have_cur) @(posedge clk);
  endtask

  task automatic wait_drained();
    wait_sent();
    while (expected_medians.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  initial begin
    int phase_idle[3];
    int n;
    int sz;
    phase_idle = '{0, 48, 13};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    push_item(0, 1'b0, 1'b1);
    push_item(32767, 1'b1, 1'b1);
    push_item(-32768, 1'b1, 1'b1);
    push_item(-32768, 1'b1, 1'b0);
    push_item(32767, 1'b1, 1'b1);
    push_item(1, 1'b1, 1'b0);
    push_item(2, 1'b1, 1'b1);
    push_item(-1, 1'b1, 1'b0);
    push_item(-2, 1'b1, 1'b1);
    push_item(5, 1'b1, 1'b0);
    push_item(5, 1'b1, 1'b0);
    push_item(0, 1'b0, 1'b0);
    push_item(5, 1'b1, 1'b0);
    push_item(0, 1'b0, 1'b1);
    push_item(3, 1'b1, 1'b0);
    push_item(-7, 1'b1, 1'b0);
    push_item(0, 1'b1, 1'b0);
    push_item(10, 1'b1, 1'b1);
    push_item(-3, 1'b1, 1'b0);
    push_item(0, 1'b1, 1'b1);
    wait_drained();

    for (int p = 0; p < 3; p++) begin
      idle_pct = phase_idle[p];
      n = 0;
      if (p == 0) begin
        n += push_set(DEPTH, 1'b0);
        n += push_set(DEPTH + 2, 1'b1);
      end
      while (n < PER_PHASE) begin
        if ($urandom_range(9) == 0) sz = $urandom_range(DEPTH + 6, DEPTH - 4);
        else sz = $urandom_range(12);
        n += push_set(sz, $urandom_range(3) == 0);
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/rsm_pkg.sv
design/rsm_cell.sv
design/running_set_median_unit.sv
tb/tb_top.sv
